// File: rtl/kpsd_pkg.sv
package kpsd_pkg;

  // Widths of the request and result fields.
  localparam int KEY_LINES_W = 9;
  localparam int CHAR_W      = 8;
  localparam int FILL_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 2;
  localparam int POS_W       = 4;

  // Default receive FIFO depth; keys beyond KEY_COUNT are never sensed.
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int KEY_COUNT      = 9;

  // Command codes.
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;

  // Character for "no key".
  localparam logic [CHAR_W-1:0] NO_KEY = 8'h00;

  // Characters of the key positions in row-major order.
  localparam logic [CHAR_W-1:0] CHAR_TABLE [KEY_LINES_W] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38
  };

  typedef struct packed {
    logic                   command;
    logic [KEY_LINES_W-1:0] key_lines;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [CHAR_W-1:0] accepted_char;
    logic              overflow;
    logic              read_valid;
    logic [CHAR_W-1:0] read_char;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

endpackage

// File: rtl/kpsd_ram.sv
module kpsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/keypad_scan_debounce_fifo.sv
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; the single output register
// refills in the cycle it is drained, and the FIFO store RAM takes one access
// per request. Reset (synchronous, rst_n low): FIFO empty, debounce history
// cleared, both scan sizes 3 by 3. The FIFO store needs no clearing pass.
module keypad_scan_debounce_fifo
  #(
  parameter int FIFO_DEPTH = kpsd_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  kpsd_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output kpsd_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kpsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kpsd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import kpsd_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [CFG_DATA_W-1:0] rows_r, rows_nxt;
  logic [CFG_DATA_W-1:0] cols_r, cols_nxt;
  logic [CHAR_W-1:0]     prev_r, prev_nxt;
  logic [CHAR_W-1:0]     last_r, last_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             res_r, res_nxt;

  logic                  in_fire;
  logic [POS_W-1:0]      scan_limit;
  logic                  hit;
  logic [POS_W-1:0]      hit_pos;
  logic [CHAR_W-1:0]     cur_char;
  logic                  fifo_full;
  logic                  push;
  logic                  pop;
  logic [CHAR_W-1:0]     ram_rd_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign fifo_full = (count_r == CNT_W'(FIFO_DEPTH));

  // Configuration writes.
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS_IN_USE: rows_nxt = cfg_data;
        CFG_COLS_IN_USE: cols_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Priority encoder: lowest pressed position inside the scanned area.
  always_comb begin
    scan_limit = POS_W'(rows_r) * POS_W'(cols_r);
    hit        = 1'b0;
    hit_pos    = '0;
    for (int i = KEY_LINES_W - 1; i >= 0; i--) begin
      if (i < KEY_COUNT && POS_W'(i) < scan_limit && !in_data.key_lines[i]) begin
        hit     = 1'b1;
        hit_pos = POS_W'(i);
      end
    end
    cur_char = hit ? CHAR_TABLE[hit_pos] : NO_KEY;
  end

  // Debounce, FIFO bookkeeping and the result register.
  always_comb begin
    prev_nxt      = prev_r;
    last_nxt      = last_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    push          = 1'b0;
    pop           = 1'b0;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_fire) begin
      res_nxt       = '0;
      out_valid_nxt = 1'b1;
      if (in_data.command == CMD_SCAN) begin
        prev_nxt = cur_char;
        if (cur_char == NO_KEY) begin
          last_nxt = NO_KEY;
        end else if (cur_char == prev_r && cur_char != last_r) begin
          last_nxt = cur_char;
          if (fifo_full) begin
            res_nxt.overflow = 1'b1;
            prev_nxt         = prev_r;
          end else begin
            push                  = 1'b1;
            res_nxt.accepted      = 1'b1;
            res_nxt.accepted_char = cur_char;
          end
        end
      end else if (count_r != '0) begin
        pop                = 1'b1;
        res_nxt.read_valid = 1'b1;
      end

      if (push) begin
        tail_nxt  = (tail_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
        count_nxt = count_r + CNT_W'(1);
      end
      if (pop) begin
        head_nxt  = (head_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
        count_nxt = count_r - CNT_W'(1);
      end
      res_nxt.fill_level = FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= CFG_DATA_W'(3);
      cols_r      <= CFG_DATA_W'(3);
      prev_r      <= NO_KEY;
      last_r      <= NO_KEY;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      prev_r      <= prev_nxt;
      last_r      <= last_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // FIFO store; a popped character arrives with its result.
  kpsd_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (push),
    .wr_addr(tail_r),
    .wr_data(cur_char),
    .rd_en  (pop),
    .rd_addr(head_r),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    out_data           = res_r;
    out_data.read_char = res_r.read_valid ? ram_rd_data : NO_KEY;
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/kpsd_checker.sv
module kpsd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input kpsd_pkg::out_item_t out_data
);
  import kpsd_pkg::*;

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Every accepted request yields a result in the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // A scan push and a read never share one result, and a push carries a key.
  a_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |->
      !out_data.read_valid && !out_data.overflow && out_data.accepted_char != NO_KEY)
    else $error("push result inconsistent");

  // A dropped key leaves no character behind.
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      out_data.accepted_char == NO_KEY && !out_data.read_valid)
    else $error("overflow result inconsistent");

  // An empty read returns no character.
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.read_valid |-> out_data.read_char == NO_KEY)
    else $error("character returned without a read");

endmodule

bind keypad_scan_debounce_fifo kpsd_checker u_kpsd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// File: tb/sv/testbench.sv
module testbench;
  import kpsd_pkg::*;

  localparam int RX_DEPTH    = FIFO_DEPTH_DEF;
  localparam int MAX_GAP     = 17;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1600;
  localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Local copy of the keypad state and scan size.
  logic [CFG_DATA_W-1:0] rows_cfg;
  logic [CFG_DATA_W-1:0] cols_cfg;
  logic [CHAR_W-1:0] prev_key;
  logic [CHAR_W-1:0] last_key;
  logic [CHAR_W-1:0] rx_queue[$];

  // Results still owed by the block, oldest first.
  out_item_t expected_results[$];

  int mismatch_count;
  int items_sent;
  int idle_cycles;
  int ready_hold;
  bit sender_idle;
  bit receiver_idle;

  keypad_scan_debounce_fifo #(
    .FIFO_DEPTH(RX_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Row-major search of the scanned area for the first key held low.
  function automatic logic [CHAR_W-1:0] first_pressed_char(input logic [KEY_LINES_W-1:0] lines);
    int pos;
    for (int r = 0; r < int'(rows_cfg); r++) begin
      for (int c = 0; c < int'(cols_cfg); c++) begin
        pos = r * int'(cols_cfg) + c;
        if (pos < KEY_COUNT && !lines[pos]) begin
          return DIGIT_ZERO + CHAR_W'(pos);
        end
      end
    end
    return NO_KEY;
  endfunction

  // Debounce, no-repeat filter and receive queue for one request.
  function automatic out_item_t predict_result(input in_item_t req);
    out_item_t res;
    logic [CHAR_W-1:0] seen;
    res = '0;
    if (req.command == CMD_SCAN) begin
      seen = first_pressed_char(req.key_lines);
      if (seen == NO_KEY) begin
        last_key = NO_KEY;
        prev_key = NO_KEY;
      end else if (seen == prev_key && seen != last_key) begin
        // The key counts as taken even when there is no room to store it.
        last_key = seen;
        if (rx_queue.size() >= RX_DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          rx_queue.push_back(seen);
          res.accepted = 1'b1;
          res.accepted_char = seen;
        end
      end else begin
        prev_key = seen;
      end
    end else if (rx_queue.size() > 0) begin
      res.read_valid = 1'b1;
      res.read_char = rx_queue.pop_front();
    end
    res.fill_level = FILL_W'(rx_queue.size());
    return res;
  endfunction

  task automatic check_field(input string name, input logic [CHAR_W-1:0] want,
                             input logic [CHAR_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Offer one request, after a random gap if sender_idle; valid holds until taken.
  task automatic send_request(input logic cmd, input logic [KEY_LINES_W-1:0] lines);
    int gap;
    in_item_t req;
    req.command = cmd;
    req.key_lines = lines;
    gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_result(req));
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ROWS_IN_USE) begin
      rows_cfg = value;
    end else begin
      cols_cfg = value;
    end
  endtask

  // Scan size changes only while the block is idle.
  task automatic set_scan_size(input logic [CFG_DATA_W-1:0] rows,
                               input logic [CFG_DATA_W-1:0] cols);
    wait_all_results();
    write_register(CFG_ROWS_IN_USE, rows);
    write_register(CFG_COLS_IN_USE, cols);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_read_when_empty();
    send_request(CMD_READ, 9'h1FF);
    wait_all_results();
  endtask

  task automatic test_debounce_and_no_repeat();
    set_scan_size(2'd3, 2'd3);
    // A held key is taken once; the third sample must not repeat it.
    repeat (3) send_request(CMD_SCAN, 9'h1FE);
    send_request(CMD_SCAN, 9'h1FF);
    // All keys low: the first position wins.
    repeat (2) send_request(CMD_SCAN, 9'h000);
    // Move to the last key without a release in between.
    repeat (2) send_request(CMD_SCAN, 9'h0FF);
    repeat (4) send_request(CMD_READ, 9'($urandom));
    wait_all_results();
  endtask

  task automatic test_scan_sizes();
    // No rows or no columns: nothing can be seen.
    set_scan_size(2'd0, 2'd3);
    repeat (2) send_request(CMD_SCAN, 9'h000);
    set_scan_size(2'd3, 2'd0);
    repeat (2) send_request(CMD_SCAN, 9'h000);
    // A single key; a press outside the area reads as a release.
    set_scan_size(2'd1, 2'd1);
    repeat (2) send_request(CMD_SCAN, 9'h1FE);
    send_request(CMD_SCAN, 9'h1FD);
    // One column: the row stride shrinks to one.
    set_scan_size(2'd3, 2'd1);
    repeat (2) send_request(CMD_SCAN, 9'h1FB);
    repeat (2) send_request(CMD_READ, 9'($urandom));
    wait_all_results();
  endtask

  task automatic test_overflow_under_backpressure();
    set_scan_size(2'd3, 2'd3);
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    // The receiver holds off at first, so the block has to stall its input;
    // distinct keys keep arriving with no reads between, so the queue overflows.
    ready_hold = 400;
    for (int k = 0; k < 20; k++) begin
      repeat (2) send_request(CMD_SCAN, ~(9'd1 << (k % KEY_COUNT)));
    end
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    repeat (RX_DEPTH + 2) send_request(CMD_READ, 9'($urandom));
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int phase_end;
    int pick;
    int n_keys;
    int pos;
    int read_weight;
    logic [CFG_DATA_W-1:0] rows;
    logic [CFG_DATA_W-1:0] cols;
    logic [KEY_LINES_W-1:0] used;
    logic [KEY_LINES_W-1:0] lines;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      // New phase: scan size, idling mode and read mix.
      rows = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      cols = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      set_scan_size(rows, cols);
      n_keys = int'(rows) * int'(cols);
      used = (9'd1 << n_keys) - 9'd1;
      sender_idle = $urandom_range(0, 2) != 0;
      receiver_idle = $urandom_range(0, 2) != 0;
      read_weight = $urandom_range(5, 40);
      phase_end = items_sent + $urandom_range(60, 200);
      while (items_sent < phase_end && items_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < read_weight) begin
          repeat ($urandom_range(1, 3)) send_request(CMD_READ, 9'($urandom));
        end else if (pick < 85 && n_keys > 0) begin
          // One key held for a few samples; later positions may be noisy.
          pos = $urandom_range(0, n_keys - 1);
          repeat ($urandom_range(1, 3)) begin
            lines = (9'($urandom) | ((9'd1 << pos) - 9'd1)) & ~(9'd1 << pos);
            send_request(CMD_SCAN, lines);
          end
        end else if (pick < 93) begin
          send_request(CMD_SCAN, 9'($urandom) | used);
        end else begin
          send_request(CMD_SCAN, 9'($urandom));
        end
      end
    end
    wait_all_results();
  endtask

  // Result receiver: random stalls per result if receiver_idle, long hold-offs on request.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (ready_hold > 0) begin
        stall = ready_hold;
        ready_hold = 0;
      end else begin
        stall = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare every delivered result with the oldest prediction.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        check_field("accepted", 8'(want.accepted), 8'(out_data.accepted));
        check_field("accepted_char", want.accepted_char, out_data.accepted_char);
        check_field("overflow", 8'(want.overflow), 8'(out_data.overflow));
        check_field("read_valid", 8'(want.read_valid), 8'(out_data.read_valid));
        check_field("read_char", want.read_char, out_data.read_char);
        check_field("fill_level", 8'(want.fill_level), 8'(out_data.fill_level));
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL keypad_scan_debounce_fifo");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rows_cfg = 2'd3;
    cols_cfg = 2'd3;
    prev_key = NO_KEY;
    last_key = NO_KEY;
    mismatch_count = 0;
    items_sent = 0;
    ready_hold = 0;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_read_when_empty();
    test_debounce_and_no_repeat();
    test_scan_sizes();
    test_overflow_under_backpressure();
    test_random_traffic();

    // Let any stray result show up before the verdict.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS keypad_scan_debounce_fifo");
    end else begin
      $display("FAIL keypad_scan_debounce_fifo");
    end
    $finish;
  end

endmodule

// File: keypad_scan_debounce_fifo.f
rtl/kpsd_pkg.sv
rtl/kpsd_ram.sv
rtl/keypad_scan_debounce_fifo.sv
rtl/kpsd_checker.sv
tb/sv/testbench.sv
